// ===== design/shaped_tile_rasterizer_top_defines.svh =====
// Assertion macros used by the shaped tile rasterizer back end.
`ifndef SHAPED_TILE_RASTERIZER_TOP_DEFINES_SVH
`define SHAPED_TILE_RASTERIZER_TOP_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define STR_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define STR_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== design/str_pkg.sv =====
// Types, constants and lookup tables of the shaped tile rasterizer.
package str_pkg;

   // Coordinate width of origins and row positions.
   localparam int COORD_BITS = 16;
   // Coordinates widened by two bits so that offsets and limits compare safely.
   localparam int EXT_BITS = COORD_BITS + 2;
   localparam int SURF_BITS = 15;
   localparam int COLOUR_BITS = 32;
   localparam int CSR_INDEX_BITS = 1;

   localparam logic [SURF_BITS-1:0] SURF_WIDTH_RESET = 15'd1024;
   localparam logic [SURF_BITS-1:0] SURF_HEIGHT_RESET = 15'd1024;
   localparam logic [COLOUR_BITS-1:0] WALL_COLOUR = 32'hFFFF_FFFF;

   // Configuration register indexes.
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SURFACE_WIDTH = 1'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SURFACE_HEIGHT = 1'd1;

   // Wall bit positions.
   localparam int WALL_WEST = 0;
   localparam int WALL_NORTH = 1;
   localparam int WALL_EAST = 2;
   localparam int WALL_SOUTH = 3;
   localparam int WALL_ANTI_DIAG = 4;
   localparam int WALL_DIAG = 5;

   // Cell index lookup for each quarter turn, indexed by {row, column}.
   localparam logic [3:0] TURN_TABLE [4][16] = '{
      '{4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7,
        4'd8, 4'd9, 4'd10, 4'd11, 4'd12, 4'd13, 4'd14, 4'd15},
      '{4'd12, 4'd8, 4'd4, 4'd0, 4'd13, 4'd9, 4'd5, 4'd1,
        4'd14, 4'd10, 4'd6, 4'd2, 4'd15, 4'd11, 4'd7, 4'd3},
      '{4'd15, 4'd14, 4'd13, 4'd12, 4'd11, 4'd10, 4'd9, 4'd8,
        4'd7, 4'd6, 4'd5, 4'd4, 4'd3, 4'd2, 4'd1, 4'd0},
      '{4'd3, 4'd7, 4'd11, 4'd15, 4'd2, 4'd6, 4'd10, 4'd14,
        4'd1, 4'd5, 4'd9, 4'd13, 4'd0, 4'd4, 4'd8, 4'd12}
   };

   // Shape masks; bit j set means cell j is foreground. The last three are empty.
   localparam logic [15:0] SHAPE_TABLE [16] = '{
      16'h0000, 16'hFFFF, 16'hF731, 16'h1133,
      16'h88CC, 16'hFFEE, 16'hFF77, 16'h3333,
      16'h3100, 16'hCEFF, 16'h113F, 16'hEEC0,
      16'hF600, 16'h0000, 16'h0000, 16'h0000
   };

   // Input item.
   typedef struct packed {
      logic signed [COORD_BITS-1:0] origin_x;
      logic signed [COORD_BITS-1:0] origin_y;
      logic [COLOUR_BITS-1:0] back_colour;
      logic [COLOUR_BITS-1:0] fore_colour;
      logic [1:0] turn;
      logic [3:0] shape_id;
      logic [5:0] wall_bits;
   } req_type;

   // Result item, one per visible row.
   typedef struct packed {
      logic signed [COORD_BITS-1:0] row_y;
      logic signed [COORD_BITS-1:0] row_x;
      logic [COLOUR_BITS-1:0] pixel_a;
      logic [COLOUR_BITS-1:0] pixel_b;
      logic [COLOUR_BITS-1:0] pixel_c;
      logic [COLOUR_BITS-1:0] pixel_d;
      logic [3:0] write_mask;
      logic last_row;
   } rsp_type;

   // Classified tile as it waits between the front and back ends.
   typedef struct packed {
      req_type tile;
      logic [3:0] row_vis;
      logic [3:0] col_vis;
   } entry_type;

   // True when cell (r, c) lies on one of the enabled wall lines.
   function automatic logic on_wall(input logic [5:0] walls, input logic [1:0] r,
                                    input logic [1:0] c);
      logic hit;
      hit = 1'b0;
      if (walls[WALL_WEST] && c == 2'd0) hit = 1'b1;
      if (walls[WALL_NORTH] && r == 2'd0) hit = 1'b1;
      if (walls[WALL_EAST] && c == 2'd3) hit = 1'b1;
      if (walls[WALL_SOUTH] && r == 2'd3) hit = 1'b1;
      if (walls[WALL_ANTI_DIAG] && c == ~r) hit = 1'b1;
      if (walls[WALL_DIAG] && c == r) hit = 1'b1;
      return hit;
   endfunction

endpackage

// ===== design/str_front.sv =====
// Front end: holds the surface registers, accepts tiles and classifies them.
module str_front (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   input  str_pkg::req_type req_data,
   input  logic csr_write_en,
   input  logic [str_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [str_pkg::SURF_BITS-1:0] csr_wdata,
   input  logic queue_full,
   output logic push,
   output str_pkg::entry_type push_entry
);

   logic [str_pkg::SURF_BITS-1:0] surf_w_ff, surf_w_in;
   logic [str_pkg::SURF_BITS-1:0] surf_h_ff, surf_h_in;
   logic [3:0] row_vis;
   logic [3:0] col_vis;
   logic x_span_on;
   logic has_colour;

   // Surface size registers.
   always_comb begin
      surf_w_in = surf_w_ff;
      surf_h_in = surf_h_ff;
      if (csr_write_en) begin
         case (csr_index)
            str_pkg::CSR_SURFACE_WIDTH: surf_w_in = csr_wdata;
            str_pkg::CSR_SURFACE_HEIGHT: surf_h_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         surf_w_ff <= str_pkg::SURF_WIDTH_RESET;
         surf_h_ff <= str_pkg::SURF_HEIGHT_RESET;
      end else begin
         surf_w_ff <= surf_w_in;
         surf_h_ff <= surf_h_in;
      end
   end

   // Visibility of the four rows and four columns against the surface.
   always_comb begin
      logic signed [str_pkg::EXT_BITS-1:0] x_ext;
      logic signed [str_pkg::EXT_BITS-1:0] y_ext;
      logic signed [str_pkg::EXT_BITS-1:0] w_ext;
      logic signed [str_pkg::EXT_BITS-1:0] h_ext;
      logic signed [str_pkg::EXT_BITS-1:0] px;
      logic signed [str_pkg::EXT_BITS-1:0] py;
      x_ext = str_pkg::EXT_BITS'(req_data.origin_x);
      y_ext = str_pkg::EXT_BITS'(req_data.origin_y);
      w_ext = $signed({3'b000, surf_w_ff});
      h_ext = $signed({3'b000, surf_h_ff});
      for (int i = 0; i < 4; i++) begin
         px = x_ext + $signed(str_pkg::EXT_BITS'(i));
         py = y_ext + $signed(str_pkg::EXT_BITS'(i));
         col_vis[i] = (px >= 0) && (px < w_ext);
         row_vis[i] = (py >= 0) && (py < h_ext);
      end
      // The tile's column span must not lie wholly left or right of the surface.
      // On a zero-width surface a tile straddling column zero still yields rows.
      x_span_on = ((x_ext + $signed(str_pkg::EXT_BITS'(3))) >= 0) && (x_ext < w_ext);
   end

   // A tile with no colour, no visible row, or lying wholly left or right of the
   // surface is dropped here.
   assign has_colour = (req_data.fore_colour != '0) || (req_data.back_colour != '0);
   assign req_ready = !queue_full;
   assign push = req_valid && req_ready && has_colour && (|row_vis) && x_span_on;

   assign push_entry.tile = req_data;
   assign push_entry.row_vis = row_vis;
   assign push_entry.col_vis = col_vis;

endmodule

// ===== design/str_queue.sv =====
// Short first-in first-out queue of classified tiles between front and back.
module str_queue #(
   parameter int DEPTH = 2
) (
   input  logic clock,
   input  logic reset,
   input  logic push,
   input  str_pkg::entry_type push_entry,
   input  logic pop,
   output logic full,
   output logic head_valid,
   output str_pkg::entry_type head
);

   localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_BITS = $clog2(DEPTH + 1);
   localparam logic [PTR_BITS-1:0] LAST_PTR = PTR_BITS'(DEPTH - 1);
   localparam logic [CNT_BITS-1:0] FULL_COUNT = CNT_BITS'(DEPTH);

   str_pkg::entry_type slots_ff [DEPTH];
   logic [PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0] count_ff, count_in;

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_entry;
      end
   end

   assign full = (count_ff == FULL_COUNT);
   assign head_valid = (count_ff != '0);
   assign head = slots_ff[rd_ptr_ff];

endmodule

// ===== design/str_back.sv =====
// Back end: walks the head tile's visible rows and renders one row per cycle unless rsp stalls.
module str_back (
   input  logic clock,
   input  logic reset,
   input  logic head_valid,
   input  str_pkg::entry_type head,
   output logic pop,
   output logic rsp_valid,
   input  logic rsp_ready,
   output str_pkg::rsp_type rsp_data
);

   `include "shaped_tile_rasterizer_top_defines.svh"

   logic [3:0] done_ff, done_in;
   logic rsp_valid_ff, rsp_valid_in;
   str_pkg::rsp_type rsp_ff, rsp_in;
   logic [3:0] remaining;
   logic [3:0] sel_hot;
   logic [1:0] sel_row;
   logic last;
   logic load;

   // Pick the lowest row of the head tile not yet sent.
   assign remaining = head.row_vis & ~done_ff;

   always_comb begin
      sel_row = 2'd0;
      sel_hot = 4'b0000;
      if (remaining[0]) begin
         sel_row = 2'd0;
         sel_hot = 4'b0001;
      end else if (remaining[1]) begin
         sel_row = 2'd1;
         sel_hot = 4'b0010;
      end else if (remaining[2]) begin
         sel_row = 2'd2;
         sel_hot = 4'b0100;
      end else if (remaining[3]) begin
         sel_row = 2'd3;
         sel_hot = 4'b1000;
      end
   end

   assign last = ((remaining & ~sel_hot) == 4'b0000);
   assign load = head_valid && (!rsp_valid_ff || rsp_ready);
   assign pop = load && last;

   // Colours and write mask of the selected row.
   always_comb begin
      logic [str_pkg::COLOUR_BITS-1:0] colour [4];
      logic [3:0] wmask;
      logic [3:0] shape_idx;
      logic fg;
      logic wr;
      for (int c = 0; c < 4; c++) begin
         shape_idx = str_pkg::TURN_TABLE[head.tile.turn][{sel_row, 2'(c)}];
         fg = str_pkg::SHAPE_TABLE[head.tile.shape_id][shape_idx];
         colour[c] = '0;
         wr = 1'b0;
         if (head.tile.fore_colour == '0) begin
            colour[c] = head.tile.back_colour;
            wr = 1'b1;
         end else if (fg) begin
            colour[c] = head.tile.fore_colour;
            wr = 1'b1;
         end else if (head.tile.back_colour != '0) begin
            colour[c] = head.tile.back_colour;
            wr = 1'b1;
         end
         if (str_pkg::on_wall(head.tile.wall_bits, sel_row, 2'(c))) begin
            colour[c] = str_pkg::WALL_COLOUR;
            wr = 1'b1;
         end
         wmask[c] = wr && head.col_vis[c];
      end
      rsp_in.row_y = head.tile.origin_y + $signed(str_pkg::COORD_BITS'(sel_row));
      rsp_in.row_x = head.tile.origin_x;
      rsp_in.pixel_a = colour[0];
      rsp_in.pixel_b = colour[1];
      rsp_in.pixel_c = colour[2];
      rsp_in.pixel_d = colour[3];
      rsp_in.write_mask = wmask;
      rsp_in.last_row = last;
   end

   // Row progress and output valid.
   always_comb begin
      done_in = done_ff;
      rsp_valid_in = rsp_valid_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
         done_in = last ? 4'b0000 : (done_ff | sel_hot);
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         done_ff <= 4'b0000;
         rsp_valid_ff <= 1'b0;
      end else begin
         done_ff <= done_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Output register payload.
   always_ff @(posedge clock) begin
      if (load) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;

   // A queued tile always has a row left to send.
   `STR_ASSERT_NOW(a_head_has_row, head_valid, remaining != 4'b0000, "head tile has no rows left")
   // Sent rows are always a subset of the head tile's visible rows.
   `STR_ASSERT_NOW(a_done_subset, head_valid, (done_ff & ~head.row_vis) == 4'b0000, "row tracking lost")
   // With the queue empty no row of a tile may be half sent.
   `STR_ASSERT_NOW(a_done_idle, !head_valid, done_ff == 4'b0000, "rows pending without a tile")
   // A pop loads the final row of the tile into the output register.
   `STR_ASSERT_NEXT(a_pop_last, pop, rsp_valid && rsp_data.last_row, "tile retired without last row")

endmodule

// ===== design/shaped_tile_rasterizer_top.sv =====
// Top level of the shaped tile rasterizer: front end, tile queue and back end.
//
//   Channel   Direction  Handshake                  Payload
//   req       in         req_valid / req_ready      req_data (str_pkg::req_type)
//   rsp       out        rsp_valid / rsp_ready      rsp_data (str_pkg::rsp_type)
//   csr       in         csr_write_en               csr_index, csr_wdata
//
// The front end takes a tile each cycle while the queue has room; tiles with no
// colour or nothing on the surface are dropped there without reaching the queue.
// The back end renders one visible row per cycle unless rsp stalls, one result per visible
// row of the tile; an accepted tile goes into a queue slot, then its rows into the output register.
// Synchronous reset empties the queue and output register and sets the surface to 1024x1024.
// A stalled rsp side holds the output register; the queue then fills and lowers req_ready.
module shaped_tile_rasterizer_top #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   input  str_pkg::req_type req_data,
   output logic rsp_valid,
   input  logic rsp_ready,
   output str_pkg::rsp_type rsp_data,
   input  logic csr_write_en,
   input  logic [str_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [str_pkg::SURF_BITS-1:0] csr_wdata
);

   logic queue_full;
   logic push;
   logic pop;
   logic head_valid;
   str_pkg::entry_type push_entry;
   str_pkg::entry_type head;

   str_front u_front (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data(req_data),
      .csr_write_en(csr_write_en),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .queue_full(queue_full),
      .push(push),
      .push_entry(push_entry)
   );

   str_queue #(
      .DEPTH(QUEUE_DEPTH)
   ) u_queue (
      .clock(clock),
      .reset(reset),
      .push(push),
      .push_entry(push_entry),
      .pop(pop),
      .full(queue_full),
      .head_valid(head_valid),
      .head(head)
   );

   str_back u_back (
      .clock(clock),
      .reset(reset),
      .head_valid(head_valid),
      .head(head),
      .pop(pop),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data(rsp_data)
   );

endmodule

// ===== tb/sv/shaped_tile_rasterizer_checker.sv =====
// Row predictor and result checker for the shaped tile rasterizer testbench.
module shaped_tile_rasterizer_checker
   import str_pkg::*;
(
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   input  logic req_ready,
   input  req_type req_data,
   input  logic rsp_valid,
   input  logic rsp_ready,
   input  rsp_type rsp_data,
   input  logic csr_write_en,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [SURF_BITS-1:0] csr_wdata,
   output int unsigned pending_rows,
   output int unsigned mismatch_count
);
   timeunit 1ns;
   timeprecision 1ps;

   // Shape cells, left to right is cell 0 to cell 15.
   localparam bit [0:15] SHAPE_CELLS [16] = '{
      16'b0000_0000_0000_0000, 16'b1111_1111_1111_1111,
      16'b1000_1100_1110_1111, 16'b1100_1100_1000_1000,
      16'b0011_0011_0001_0001, 16'b0111_0111_1111_1111,
      16'b1110_1110_1111_1111, 16'b1100_1100_1100_1100,
      16'b0000_0000_1000_1100, 16'b1111_1111_0111_0011,
      16'b1111_1100_1000_1000, 16'b0000_0011_0111_0111,
      16'b0000_0000_0110_1111, 16'b0000_0000_0000_0000,
      16'b0000_0000_0000_0000, 16'b0000_0000_0000_0000
   };

   // Cell looked up for each pixel position under each quarter turn.
   localparam int TURN_MAP [4][16] = '{
      '{0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11, 12, 13, 14, 15},
      '{12, 8, 4, 0, 13, 9, 5, 1, 14, 10, 6, 2, 15, 11, 7, 3},
      '{15, 14, 13, 12, 11, 10, 9, 8, 7, 6, 5, 4, 3, 2, 1, 0},
      '{3, 7, 11, 15, 2, 6, 10, 14, 1, 5, 9, 13, 0, 4, 8, 12}
   };

   localparam logic [31:0] WHITE = 32'hFFFF_FFFF;

   rsp_type tile_rows_q [$];
   int surf_w;
   int surf_h;

   initial begin
      pending_rows = 0;
      mismatch_count = 0;
      surf_w = SURF_WIDTH_RESET;
      surf_h = SURF_HEIGHT_RESET;
   end

   // True when pixel (r, c) lies on any enabled wall line.
   function automatic bit wall_hit(input logic [5:0] walls, input int r, input int c);
      return (walls[WALL_WEST] && c == 0) || (walls[WALL_NORTH] && r == 0) ||
             (walls[WALL_EAST] && c == 3) || (walls[WALL_SOUTH] && r == 3) ||
             (walls[WALL_ANTI_DIAG] && r + c == 3) || (walls[WALL_DIAG] && r == c);
   endfunction

   // Works out the visible rows of one tile and queues them in row order.
   function automatic void predict_tile_rows(input req_type t);
      int ox;
      int oy;
      int ry;
      int n;
      logic [31:0] px [4];
      logic [3:0] mask;
      logic [31:0] colour;
      bit written;
      bit fg;
      rsp_type rows [4];
      ox = $signed(t.origin_x);
      oy = $signed(t.origin_y);
      n = 0;
      // No colour at all, or nothing of the tile on the surface.
      if (t.fore_colour == '0 && t.back_colour == '0) return;
      if (ox + 3 < 0 || ox >= surf_w || oy + 3 < 0 || oy >= surf_h) return;
      for (int r = 0; r < 4; r++) begin
         ry = oy + r;
         if (ry < 0 || ry >= surf_h) continue;
         mask = '0;
         for (int c = 0; c < 4; c++) begin
            colour = '0;
            written = 1'b0;
            if (t.fore_colour == '0) begin
               colour = t.back_colour;
               written = 1'b1;
            end else begin
               fg = SHAPE_CELLS[t.shape_id][TURN_MAP[t.turn][r * 4 + c]];
               if (fg) begin
                  colour = t.fore_colour;
                  written = 1'b1;
               end else if (t.back_colour != '0) begin
                  colour = t.back_colour;
                  written = 1'b1;
               end
            end
            if (wall_hit(t.wall_bits, r, c)) begin
               colour = WHITE;
               written = 1'b1;
            end
            px[c] = colour;
            // Columns off the surface keep their colour but are not written.
            if (written && ox + c >= 0 && ox + c < surf_w) mask[c] = 1'b1;
         end
         rows[n].row_y = ry[15:0];
         rows[n].row_x = t.origin_x;
         rows[n].pixel_a = px[0];
         rows[n].pixel_b = px[1];
         rows[n].pixel_c = px[2];
         rows[n].pixel_d = px[3];
         rows[n].write_mask = mask;
         rows[n].last_row = 1'b0;
         n++;
      end
      if (n > 0) rows[n - 1].last_row = 1'b1;
      for (int i = 0; i < n; i++) tile_rows_q.push_back(rows[i]);
   endfunction

   // Counts a wrong field and reports the first few.
   function automatic void check_field(input string field, input logic [31:0] want,
                                       input logic [31:0] got);
      if (want !== got) begin
         mismatch_count++;
         if (mismatch_count <= 10)
            $display("%0t: %s mismatch: expected %h, got %h", $realtime, field, want, got);
      end
   endfunction

   // Track register writes, queue predictions and compare each accepted row.
   always @(posedge clock) begin : watch
      rsp_type want;
      if (reset) begin
         surf_w = SURF_WIDTH_RESET;
         surf_h = SURF_HEIGHT_RESET;
         tile_rows_q.delete();
      end else begin
         if (csr_write_en) begin
            if (csr_index == CSR_SURFACE_WIDTH) surf_w = csr_wdata;
            else if (csr_index == CSR_SURFACE_HEIGHT) surf_h = csr_wdata;
         end
         if (req_valid && req_ready) predict_tile_rows(req_data);
         if (rsp_valid && rsp_ready) begin
            if (tile_rows_q.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("%0t: row result with no row expected: row_y %h row_x %h",
                           $realtime, rsp_data.row_y, rsp_data.row_x);
            end else begin
               want = tile_rows_q.pop_front();
               check_field("row_y", want.row_y, rsp_data.row_y);
               check_field("row_x", want.row_x, rsp_data.row_x);
               check_field("pixel_a", want.pixel_a, rsp_data.pixel_a);
               check_field("pixel_b", want.pixel_b, rsp_data.pixel_b);
               check_field("pixel_c", want.pixel_c, rsp_data.pixel_c);
               check_field("pixel_d", want.pixel_d, rsp_data.pixel_d);
               check_field("write_mask", want.write_mask, rsp_data.write_mask);
               check_field("last_row", want.last_row, rsp_data.last_row);
            end
         end
      end
      pending_rows <= tile_rows_q.size();
   end

endmodule

// ===== tb/sv/shaped_tile_rasterizer_top_tb.sv =====
// Testbench top for the shaped tile rasterizer: stimulus, row sink and verdict.
module shaped_tile_rasterizer_top_tb;
   import str_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int LONG_STALL_CYCLES = 80;
   localparam int SETTLE_CYCLES = 10;

   logic clock = 1'b0;
   logic reset;
   logic req_valid;
   logic req_ready;
   req_type req_data;
   logic rsp_valid;
   logic rsp_ready;
   rsp_type rsp_data;
   logic csr_write_en;
   logic [CSR_INDEX_BITS-1:0] csr_index;
   logic [SURF_BITS-1:0] csr_wdata;
   int unsigned pending_rows;
   int unsigned mismatch_count;

   // Surface size as last programmed, used to aim origins at the edges.
   int surf_w;
   int surf_h;
   int burst_left;
   bit no_gaps;
   bit long_stall_go;
   bit long_stall_done;

   shaped_tile_rasterizer_top u_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data(rsp_data),
      .csr_write_en(csr_write_en),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   shaped_tile_rasterizer_checker u_checker (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data(rsp_data),
      .csr_write_en(csr_write_en),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .pending_rows(pending_rows),
      .mismatch_count(mismatch_count)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Safety net against a hung handshake.
   initial begin
      #400000;
      $display("shaped_tile_rasterizer_top_tb: errors");
      $finish;
   end

   function automatic req_type make_tile(input int x, input int y, input logic [31:0] back,
                                         input logic [31:0] fore, input int turn,
                                         input int shape, input logic [5:0] walls);
      req_type t;
      t.origin_x = x[15:0];
      t.origin_y = y[15:0];
      t.back_colour = back;
      t.fore_colour = fore;
      t.turn = turn[1:0];
      t.shape_id = shape[3:0];
      t.wall_bits = walls;
      return t;
   endfunction

   // Origin coordinate: mostly on the surface, often straddling an edge.
   function automatic int pick_coord(input int span);
      int v;
      case ($urandom_range(0, 9))
         0: v = $urandom;
         1, 2: v = int'($urandom_range(0, 8)) - 5;
         3, 4: v = span + int'($urandom_range(0, 5)) - 4;
         default: v = (span > 0) ? int'($urandom_range(0, span - 1)) : 0;
      endcase
      return v;
   endfunction

   function automatic logic [31:0] pick_colour();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return 32'hFFFF_FFFF;
         default: return $urandom;
      endcase
   endfunction

   function automatic req_type random_tile();
      logic [5:0] walls;
      walls = ($urandom_range(0, 1) == 0) ? 6'd0 : 6'($urandom_range(0, 63));
      return make_tile(pick_coord(surf_w), pick_coord(surf_h), pick_colour(), pick_colour(),
                       $urandom_range(0, 3), $urandom_range(0, 15), walls);
   endfunction

   // Offers one item and returns at the edge that accepts it.
   task automatic send_tile(input req_type t);
      req_valid <= 1'b1;
      req_data <= t;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // Sends an item, then keeps the burst going or drops valid for a gap.
   task automatic offer_tile(input req_type t);
      send_tile(t);
      if (!no_gaps) begin
         if (burst_left == 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clock);
            burst_left = $urandom_range(0, 12);
         end else begin
            burst_left--;
         end
      end
   endtask

   task automatic random_tiles(input int count);
      for (int i = 0; i < count; i++) offer_tile(random_tile());
   endtask

   // Waits until every expected row has come back and the pipeline is quiet.
   task automatic finish_phase();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_rows != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Programs both surface registers; only called while the block is idle.
   task automatic set_surface(input int w, input int h);
      csr_write_en <= 1'b1;
      csr_index <= CSR_SURFACE_WIDTH;
      csr_wdata <= w[SURF_BITS-1:0];
      @(posedge clock);
      csr_index <= CSR_SURFACE_HEIGHT;
      csr_wdata <= h[SURF_BITS-1:0];
      @(posedge clock);
      csr_write_en <= 1'b0;
      surf_w = w;
      surf_h = h;
   endtask

   // Row sink: random stall patterns, plus one long hold-off on request.
   initial begin : row_sink
      int mode;
      int seg_left;
      int beat;
      rsp_ready = 1'b0;
      long_stall_done = 1'b0;
      mode = 0;
      seg_left = 0;
      beat = 0;
      forever begin
         if (long_stall_go && !long_stall_done) begin
            rsp_ready <= 1'b0;
            repeat (LONG_STALL_CYCLES) @(posedge clock);
            long_stall_done = 1'b1;
         end else begin
            if (seg_left == 0) begin
               mode = $urandom_range(0, 3);
               seg_left = $urandom_range(10, 120);
            end
            seg_left--;
            beat++;
            case (mode)
               0: rsp_ready <= 1'b1;
               1: rsp_ready <= 1'($urandom_range(0, 1));
               2: rsp_ready <= ($urandom_range(0, 3) == 0);
               default: rsp_ready <= (beat % 5) < 3;
            endcase
            @(posedge clock);
         end
      end
   end

   initial begin : stimulus
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      csr_write_en = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      surf_w = SURF_WIDTH_RESET;
      surf_h = SURF_HEIGHT_RESET;
      burst_left = 0;
      no_gaps = 1'b0;
      long_stall_go = 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed tiles on the reset-size surface.
      // Background only, then foreground only, then both under turns 1, 2 and 3.
      offer_tile(make_tile(0, 0, 32'hAA55_AA55, 32'h0, 0, 0, 6'd0));
      offer_tile(make_tile(4, 0, 32'h0, 32'h1234_5678, 0, 2, 6'd0));
      offer_tile(make_tile(8, 0, 32'h1111_1111, 32'h2222_2222, 1, 2, 6'd0));
      offer_tile(make_tile(12, 0, 32'h1111_1111, 32'h2222_2222, 2, 3, 6'd0));
      offer_tile(make_tile(16, 0, 32'h1111_1111, 32'h2222_2222, 3, 4, 6'd0));
      // No colour at all, even with every wall set: nothing comes out.
      offer_tile(make_tile(0, 4, 32'h0, 32'h0, 0, 1, 6'd63));
      // Tiles just off each edge of the surface.
      offer_tile(make_tile(-4, 0, 32'h5, 32'h6, 0, 1, 6'd0));
      offer_tile(make_tile(1024, 0, 32'h5, 32'h6, 0, 1, 6'd0));
      offer_tile(make_tile(0, -4, 32'h5, 32'h6, 0, 1, 6'd0));
      offer_tile(make_tile(0, 1024, 32'h5, 32'h6, 0, 1, 6'd0));
      // Corner clipping: one visible pixel, then the far corner with all walls.
      offer_tile(make_tile(-3, -3, 32'h0, 32'hFFFF_FFFF, 0, 1, 6'd0));
      offer_tile(make_tile(1021, 1021, 32'h1, 32'h8000_0000, 1, 9, 6'd63));
      // Origin extremes.
      offer_tile(make_tile(-32768, -32768, 32'h7, 32'h8, 0, 5, 6'd0));
      offer_tile(make_tile(32767, 32767, 32'h7, 32'h8, 0, 6, 6'd0));
      // One wall at a time over an empty shape.
      for (int i = 0; i < 6; i++)
         offer_tile(make_tile(20 + 4 * i, 8, 32'h0, 32'h0BAD_F00D, i % 4, 13 + i % 3,
                              6'd1 << i));
      // Visible rows with nothing to write, then an empty shape over a background.
      offer_tile(make_tile(48, 8, 32'h0, 32'h0000_0001, 0, 13, 6'd0));
      offer_tile(make_tile(52, 8, 32'hC0FF_EE00, 32'h0000_0001, 2, 15, 6'd0));
      finish_phase();

      // Random tiles, with the sink held off for a long stretch in the middle.
      random_tiles(30);
      no_gaps = 1'b1;
      long_stall_go = 1'b1;
      random_tiles(40);
      no_gaps = 1'b0;
      random_tiles(30);
      finish_phase();

      set_surface(32767, 32767);
      random_tiles(80);
      finish_phase();

      // Zero surface: every tile is off it.
      set_surface(0, 0);
      random_tiles(10);
      finish_phase();

      set_surface(1, 1);
      random_tiles(30);
      finish_phase();

      set_surface(3, 5);
      random_tiles(60);
      finish_phase();

      set_surface($urandom_range(4, 200), $urandom_range(4, 200));
      random_tiles(130);
      finish_phase();

      if (mismatch_count == 0 && pending_rows == 0) begin
         $display("shaped_tile_rasterizer_top_tb: clean");
      end else begin
         $display("shaped_tile_rasterizer_top_tb: errors");
      end
      $finish;
   end

endmodule
